/* rtl/lspa_pkg.sv */
// Shared constants, sine table type and table builder for the lidar scan area block.
package lspa_pkg;

  // Quarter-wave sine table depth
  localparam int unsigned SINE_DEPTH = 1024;
  localparam int unsigned IDX_W = $clog2(SINE_DEPTH);

  // Angles in 1/64 degree
  localparam int unsigned QUARTER_TURN = 5760;
  localparam int unsigned FULL_TURN = 23040;

  // Scaled offset u*SINE_DEPTH and its exact divide by QUARTER_TURN
  localparam int unsigned SCALED_W = $clog2(QUARTER_TURN * SINE_DEPTH + 1);
  localparam int unsigned IDX_SHIFT = 40;
  localparam longint unsigned IDX_RECIP =
      ((64'd1 << IDX_SHIFT) + 64'(QUARTER_TURN) - 64'd1) / 64'(QUARTER_TURN);

  // Shared multiplier operand width
  localparam int unsigned MUL_W = 32;

  localparam logic [14:0] SINE_MAX = 15'h7FFF;
  localparam logic [15:0] POINTS_RESET = 16'd1000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Series divisors (2n)*(2n+1) for n = 1..8
  localparam longint unsigned SERIES_DIV [8] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic [14:0] sine_rom_t [SINE_DEPTH];

  // Build the Q15 quarter-wave table: Q30 Taylor series, round half up, clamp
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint sum;
    for (int unsigned k = 0; k < SINE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int unsigned n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / SERIES_DIV[n-1];
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      rom[k] = q[14:0];
    end
    return rom;
  endfunction

endpackage

/* rtl/lspa_mul.sv */
// Shared unsigned multiplier with a registered product.
module lspa_mul (
  input  logic                             clk,
  input  logic [lspa_pkg::MUL_W-1:0]       op_a,
  input  logic [lspa_pkg::MUL_W-1:0]       op_b,
  output logic [2*lspa_pkg::MUL_W-1:0]     prod_r
);
  import lspa_pkg::*;

  // Register the product every cycle; the sequencer picks the operands
  always_ff @(posedge clk) begin
    prod_r <= (2*MUL_W)'(op_a) * (2*MUL_W)'(op_b);
  end

endmodule

/* rtl/lspa_sine_rom.sv */
// Quarter-wave Q15 sine table with a registered read port.
module lspa_sine_rom (
  input  logic                       clk,
  input  logic [lspa_pkg::IDX_W-1:0] rd_addr,
  output logic [14:0]                rd_data_r
);
  import lspa_pkg::*;

  localparam sine_rom_t ROM = build_sine_rom();

  // Read one entry per cycle
  always_ff @(posedge clk) begin
    rd_data_r <= ROM[rd_addr];
  end

endmodule

/* rtl/lidar_scan_polar_area_top.sv */
// Top level: packet framing, point output and the polar area sequencer.
//
// Bytes are taken one per cycle while the sequencer is idle; the first four
// bytes of a packet are only stored. The fifth byte of a data packet starts
// the sequencer, which runs each cross-product term through one shared
// 32x32 multiplier and the sine table: one term for a middle point; for the
// final point of a scan, its middle and closing terms and the area step;
// one closing term and the area step for a scan of one point; none for the
// first point of a longer scan. A finished item waits in the output
// register while further bytes are accepted; the sequencer only stalls
// if it completes another item before the waiting one is taken.
module lidar_scan_polar_area_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_point_distance,
  output logic [14:0] out_point_angle,
  output logic [15:0] out_point_number,
  output logic [42:0] out_area_mm2,
  output logic        out_scan_done
);
  import lspa_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_DIFF  = 11'b000_0000_0010,
    ST_QUAD  = 11'b000_0000_0100,
    ST_SCALE = 11'b000_0000_1000,
    ST_IDXM  = 11'b000_0001_0000,
    ST_IDX   = 11'b000_0010_0000,
    ST_ROMRD = 11'b000_0100_0000,
    ST_TERMM = 11'b000_1000_0000,
    ST_ACC   = 11'b001_0000_0000,
    ST_FIN   = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Control state
  logic [15:0] ppscan_r;
  logic        hunting_r;
  logic [2:0]  byte_pos_r;
  logic [15:0] points_seen_r;
  logic        second_r;
  logic        out_valid_r;

  // Payload state
  logic [7:0]  pkt_r [4];
  logic [15:0] first_d_r, prev_d_r;
  logic [14:0] first_a_r, prev_a_r;
  logic [63:0] acc_r;
  logic [15:0] res_d_r, res_num_r;
  logic [14:0] res_a_r;
  logic        res_done_r;
  logic [15:0] op_d0_r, op_d1_r;
  logic [14:0] op_a0_r, op_a1_r;
  logic [14:0] diff_r;
  logic [1:0]  quad_r;
  logic [12:0] u_r;
  logic        sat_r;
  logic [SCALED_W-1:0] scaled_r;
  logic [IDX_W-1:0]    idx_r;
  logic [31:0] dd_r;
  logic [42:0] fin_area_r;
  logic [15:0] out_d_r, out_num_r;
  logic [14:0] out_a_r;
  logic [42:0] out_area_r;
  logic        out_done_r;

  // Shared unit wiring
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod_r;
  logic [14:0]        rom_q_r;

  lspa_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  lspa_sine_rom u_rom (
    .clk       (clk),
    .rd_addr   (idx_r),
    .rd_data_r (rom_q_r)
  );

  // Byte framing view
  logic        in_fire;
  logic [15:0] cur_d;
  logic [14:0] cur_a;
  logic [15:0] seen_inc;
  logic        cur_done;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign cur_d    = {in_rx_byte, pkt_r[3]};
  assign cur_a    = {pkt_r[2], pkt_r[1][7:1]};
  assign seen_inc = points_seen_r + 16'd1;
  assign cur_done = (seen_inc == ppscan_r);

  // Angle difference reduced into one turn
  logic [16:0] diff_raw;
  logic [14:0] diff_mod;
  assign diff_raw = 17'(op_a1_r) + 17'(2 * FULL_TURN) - 17'(op_a0_r);
  always_comb begin
    if (diff_raw >= 17'(3 * FULL_TURN)) begin
      diff_mod = 15'(diff_raw - 17'(3 * FULL_TURN));
    end else if (diff_raw >= 17'(2 * FULL_TURN)) begin
      diff_mod = 15'(diff_raw - 17'(2 * FULL_TURN));
    end else if (diff_raw >= 17'(FULL_TURN)) begin
      diff_mod = 15'(diff_raw - 17'(FULL_TURN));
    end else begin
      diff_mod = diff_raw[14:0];
    end
  end

  // Quadrant and mirrored offset
  logic [1:0]  quad_c;
  logic [12:0] rem_c;
  logic [12:0] u_c;
  always_comb begin
    if (diff_r >= 15'(3 * QUARTER_TURN)) begin
      quad_c = 2'd3;
      rem_c  = 13'(diff_r - 15'(3 * QUARTER_TURN));
    end else if (diff_r >= 15'(2 * QUARTER_TURN)) begin
      quad_c = 2'd2;
      rem_c  = 13'(diff_r - 15'(2 * QUARTER_TURN));
    end else if (diff_r >= 15'(QUARTER_TURN)) begin
      quad_c = 2'd1;
      rem_c  = 13'(diff_r - 15'(QUARTER_TURN));
    end else begin
      quad_c = 2'd0;
      rem_c  = diff_r[12:0];
    end
    u_c = quad_c[0] ? (13'(QUARTER_TURN) - rem_c) : rem_c;
  end

  // Table index from the reciprocal product, clamped to the last entry
  logic [IDX_W:0] idx_full;
  logic [IDX_W-1:0] idx_c;
  assign idx_full = prod_r[IDX_SHIFT +: IDX_W+1];
  assign idx_c = (idx_full >= (IDX_W+1)'(SINE_DEPTH)) ? IDX_W'(SINE_DEPTH - 1)
                                                       : idx_full[IDX_W-1:0];

  // Sine magnitude for the term
  logic [14:0] sine_c;
  assign sine_c = sat_r ? SINE_MAX : rom_q_r;

  // Operand select for the shared multiplier
  always_comb begin
    case (state_r)
      ST_IDXM: begin
        mul_a = MUL_W'(scaled_r);
        mul_b = MUL_W'(IDX_RECIP);
      end
      ST_IDX: begin
        mul_a = MUL_W'(op_d0_r);
        mul_b = MUL_W'(op_d1_r);
      end
      ST_TERMM: begin
        mul_a = dd_r;
        mul_b = MUL_W'(sine_c);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Magnitude of the sum, halved to mm^2 and saturated
  logic [63:0] mag_c;
  assign mag_c = acc_r[63] ? (64'd0 - acc_r) : acc_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && byte_pos_r == 3'd4 && !hunting_r) begin
          if (points_seen_r != 16'd0 || cur_done) begin
            state_nxt = ST_DIFF;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DIFF:  state_nxt = ST_QUAD;
      ST_QUAD:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_IDXM;
      ST_IDXM:  state_nxt = ST_IDX;
      ST_IDX:   state_nxt = ST_ROMRD;
      ST_ROMRD: state_nxt = ST_TERMM;
      ST_TERMM: state_nxt = ST_ACC;
      ST_ACC: begin
        if (second_r) begin
          state_nxt = ST_DIFF;
        end else if (res_done_r) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_FIN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ppscan_r      <= POINTS_RESET;
      hunting_r     <= 1'b1;
      byte_pos_r    <= 3'd0;
      points_seen_r <= 16'd0;
      second_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      acc_r         <= 64'd0;
      first_d_r     <= 16'd0;
      first_a_r     <= 15'd0;
      prev_d_r      <= 16'd0;
      prev_a_r      <= 15'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        ppscan_r <= cfg_wdata;
      end
      // Frame bytes and take the packet decision on the fifth
      if (in_fire) begin
        if (byte_pos_r != 3'd4) begin
          byte_pos_r <= byte_pos_r + 3'd1;
        end else begin
          byte_pos_r <= 3'd0;
          if (hunting_r) begin
            if (pkt_r[0][0]) begin
              hunting_r     <= 1'b0;
              points_seen_r <= 16'd0;
              acc_r         <= 64'd0;
            end
          end else begin
            if (points_seen_r == 16'd0) begin
              first_d_r <= cur_d;
              first_a_r <= cur_a;
            end
            prev_d_r      <= cur_d;
            prev_a_r      <= cur_a;
            points_seen_r <= seen_inc;
            second_r      <= (points_seen_r != 16'd0) && cur_done;
            if (cur_done) begin
              hunting_r <= 1'b1;
            end
          end
        end
      end
      // Add or subtract the finished term
      if (state_r == ST_ACC) begin
        acc_r <= quad_r[1] ? (acc_r - prod_r) : (acc_r + prod_r);
        if (second_r) begin
          second_r <= 1'b0;
        end
      end
      // Hand the item to the output register
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire && byte_pos_r != 3'd4) begin
      pkt_r[byte_pos_r[1:0]] <= in_rx_byte;
    end
    if (in_fire && byte_pos_r == 3'd4 && !hunting_r) begin
      res_d_r    <= cur_d;
      res_a_r    <= cur_a;
      res_num_r  <= points_seen_r;
      res_done_r <= cur_done;
      if (points_seen_r != 16'd0) begin
        op_d0_r <= prev_d_r;
        op_a0_r <= prev_a_r;
        op_d1_r <= cur_d;
        op_a1_r <= cur_a;
      end else begin
        op_d0_r <= cur_d;
        op_a0_r <= cur_a;
        op_d1_r <= cur_d;
        op_a1_r <= cur_a;
      end
    end
    // Load the closing term operands after the middle term
    if (state_r == ST_ACC && second_r) begin
      op_d0_r <= res_d_r;
      op_a0_r <= res_a_r;
      op_d1_r <= first_d_r;
      op_a1_r <= first_a_r;
    end
    if (state_r == ST_DIFF) begin
      diff_r <= diff_mod;
    end
    if (state_r == ST_QUAD) begin
      quad_r <= quad_c;
      u_r    <= u_c;
      sat_r  <= (u_c == 13'(QUARTER_TURN));
    end
    if (state_r == ST_SCALE) begin
      scaled_r <= SCALED_W'(u_r) * SCALED_W'(SINE_DEPTH);
    end
    if (state_r == ST_IDX) begin
      idx_r <= idx_c;
    end
    if (state_r == ST_ROMRD) begin
      dd_r <= prod_r[31:0];
    end
    if (state_r == ST_FIN) begin
      fin_area_r <= mag_c[63] ? {43{1'b1}} : mag_c[62:20];
    end
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_d_r    <= res_d_r;
      out_a_r    <= res_a_r;
      out_num_r  <= res_num_r;
      out_done_r <= res_done_r;
      out_area_r <= res_done_r ? fin_area_r : 43'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_point_distance = out_d_r;
  assign out_point_angle    = out_a_r;
  assign out_point_number   = out_num_r;
  assign out_area_mm2       = out_area_r;
  assign out_scan_done      = out_done_r;

endmodule

/* rtl/lspa_checker.sv */
// Port-level checks for the lidar scan area block, bound to the top level.
module lspa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_point_distance,
  input logic [14:0] out_point_angle,
  input logic [15:0] out_point_number,
  input logic [42:0] out_area_mm2,
  input logic        out_scan_done
);

  // Hold a stalled result item unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_distance) &&
      $stable(out_point_angle) && $stable(out_point_number) &&
      $stable(out_area_mm2) && $stable(out_scan_done))
    else $error("result item changed while stalled");

  // Report area only on the final point of a scan
  a_area_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_scan_done |-> out_area_mm2 == 43'd0)
    else $error("area nonzero on a point that does not end the scan");

  // Drop any result item on reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // Accept bytes again right after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind lidar_scan_polar_area_top lspa_checker u_lspa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_point_distance (out_point_distance),
  .out_point_angle    (out_point_angle),
  .out_point_number   (out_point_number),
  .out_area_mm2       (out_area_mm2),
  .out_scan_done      (out_scan_done)
);
